// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/md5_pkg.sv =====
package md5_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS_INT = 448 / 8;
    localparam logic [5:0] LEN_POS = 6'(LEN_POS_INT);
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef logic [1:0] op_t;
    localparam op_t OP_BYTE     = 2'd0;
    localparam op_t OP_BYTE_END = 2'd1;
    localparam op_t OP_END      = 2'd2;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [4][4] = '{
        '{5'd7, 5'd12, 5'd17, 5'd22},
        '{5'd5, 5'd9,  5'd14, 5'd20},
        '{5'd4, 5'd11, 5'd16, 5'd23},
        '{5'd6, 5'd10, 5'd15, 5'd21}
    };

endpackage

// ===== rtl/md5_front.sv =====
module md5_front
(
    input  logic          [7:0] data_byte,
    input  logic          byte_present,
    input  logic          message_end,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          full,
    output logic          push_valid,
    output md5_pkg::item_t push_item
);

    logic keep;
    md5_pkg::op_t op;

    always_comb
    begin
        keep = 1'b1;
        op   = md5_pkg::OP_BYTE;
        unique case ({byte_present, message_end})
            2'b10:
            begin
                op = md5_pkg::OP_BYTE;
            end
            2'b11:
            begin
                op = md5_pkg::OP_BYTE_END;
            end
            2'b01:
            begin
                op = md5_pkg::OP_END;
            end
            2'b00:
            begin
                // drop empty items
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall       = full;
    assign push_valid     = in_valid && !full && keep;
    assign push_item.op   = op;
    assign push_item.data = data_byte;

endmodule

// ===== rtl/md5_queue.sv =====
`include "assert_macros.svh"

module md5_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  md5_pkg::item_t push_item,
    output logic           full,
    output logic           pop_valid,
    output md5_pkg::item_t pop_item,
    input  logic           pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    md5_pkg::item_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_push_full, push_valid && full, "item pushed into a full queue")
    `ASSERT_CLK(a_count_max, count_reg <= CNT_W'(DEPTH), "queue count above depth")

endmodule

// ===== rtl/md5_back.sv =====
`include "assert_macros.svh"

module md5_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  md5_pkg::item_t q_item,
    output logic           q_pop,
    output logic [31:0]    digest_word,
    output logic [1:0]     word_number,
    output logic           digest_last,
    output logic           out_valid,
    input  logic           out_stall
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD_MARK = 3'd1;
    localparam logic [2:0] ST_PAD_ZERO = 3'd2;
    localparam logic [2:0] ST_ROUND    = 3'd3;
    localparam logic [2:0] ST_ADD      = 3'd4;
    localparam logic [2:0] ST_EMIT     = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  ret_reg, ret_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [60:0] total_reg, total_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [1:0]  emit_reg, emit_next;
    logic [31:0] words_reg [16];

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic [1:0]  out_num_reg, out_num_next;
    logic        out_last_reg, out_last_next;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        len_en;
    logic        start;

    logic [1:0]  grp;
    logic [3:0]  i4;
    logic [3:0]  g;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  s;

    assign grp = round_reg[5:4];
    assign i4  = round_reg[3:0];
    assign s   = md5_pkg::ROT_S[grp][round_reg[1:0]];

    always_comb
    begin
        unique case (grp)
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = i4;
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = (i4 << 2) + i4 + 4'd1;
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = (i4 << 1) + i4 + 4'd5;
            end
            2'd3:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = (i4 << 3) - i4;
            end
        endcase
    end

    assign sum = a_reg + f + md5_pkg::SINE_K[round_reg] + words_reg[g];
    assign dbl = {sum, sum} << s;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        total_next     = total_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_byte        = 8'h00;
        len_en         = 1'b0;
        start          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    priority case (q_item.op)
                        md5_pkg::OP_BYTE, md5_pkg::OP_BYTE_END:
                        begin
                            wr_en      = 1'b1;
                            wr_byte    = q_item.data;
                            total_next = total_reg + 61'd1;
                            fill_next  = fill_reg + 6'd1;
                            ret_next   = (q_item.op == md5_pkg::OP_BYTE_END) ?
                                         ST_PAD_MARK : ST_IDLE;
                            if (fill_reg == md5_pkg::LAST_POS)
                            begin
                                start = 1'b1;
                            end
                            else
                            begin
                                state_next = ret_next;
                            end
                        end
                        md5_pkg::OP_END:
                        begin
                            state_next = ST_PAD_MARK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD_MARK:
            begin
                wr_en     = 1'b1;
                wr_byte   = md5_pkg::PAD_BYTE;
                fill_next = fill_reg + 6'd1;
                ret_next  = ST_PAD_ZERO;
                if (fill_reg == md5_pkg::LAST_POS)
                begin
                    start = 1'b1;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == md5_pkg::LEN_POS)
                begin
                    len_en   = 1'b1;
                    ret_next = ST_EMIT;
                    start    = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    ret_next  = ST_PAD_ZERO;
                    if (fill_reg == md5_pkg::LAST_POS)
                    begin
                        start = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + dbl[63:32];
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                state_next    = ret_reg;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[emit_reg];
                    out_num_next   = emit_reg;
                    out_last_next  = (emit_reg == 2'd3);
                    emit_next      = emit_reg + 2'd1;
                    if (emit_reg == 2'd3)
                    begin
                        chain_next[0] = md5_pkg::H0;
                        chain_next[1] = md5_pkg::H1;
                        chain_next[2] = md5_pkg::H2;
                        chain_next[3] = md5_pkg::H3;
                        total_next    = '0;
                        fill_next     = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            round_next = '0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            chain_reg[0]  <= md5_pkg::H0;
            chain_reg[1]  <= md5_pkg::H1;
            chain_reg[2]  <= md5_pkg::H2;
            chain_reg[3]  <= md5_pkg::H3;
            total_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            chain_reg     <= chain_next;
            total_reg     <= total_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        out_word_reg <= out_word_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
        if (wr_en)
        begin
            words_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (len_en)
        begin
            words_reg[14] <= {total_reg[28:0], 3'b000};
            words_reg[15] <= total_reg[60:29];
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_number = out_num_reg;
    assign digest_last = out_last_reg;

    `ASSERT_CLK(a_round_rest, (state_reg != ST_ROUND) |-> (round_reg == 6'd0), "round count off")
    `ASSERT_CLK(a_pop_idle, q_pop |-> (state_reg == ST_IDLE), "queue popped while busy")

endmodule

// ===== rtl/md5_message_digest_core.sv =====
// MD5 digest core.
// Input channel: data_byte, byte_present, message_end with in_valid/in_stall.
// Each item carries one message byte; message_end marks the last item, and
// byte_present low with message_end high ends a message without a byte.
// Items with neither flag are dropped.
// Output channel: digest_word, word_number, digest_last with out_valid/out_stall.
// Four items per message, h0 first, digest_last on h3.
// Accepted items enter a small queue; the compression engine drains it.
// Bytes are taken one per cycle while idle; each full chunk is compressed in
// 64 rounds and one add. Padding is written one byte per cycle with one or two
// compressions; digest words then leave one per cycle unless the output stalls.
// The input stalls only while the queue is full.
// A stalled output holds its word; the engine waits until it is taken.
// Reset clears the queue and loads the MD5 initial chain value.
module md5_message_digest_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_number,
    output logic        digest_last,
    output logic        out_valid,
    input  logic        out_stall
);

    logic           full;
    logic           push_valid;
    md5_pkg::item_t push_item;
    logic           pop_valid;
    md5_pkg::item_t pop_item;
    logic           pop;

    md5_front u_front
    (
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .full         (full),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    md5_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    md5_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (pop_valid),
        .q_item      (pop_item),
        .q_pop       (pop),
        .digest_word (digest_word),
        .word_number (word_number),
        .digest_last (digest_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam logic [31:0] MD5_SINE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int MD5_ROT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam int unsigned LENGTH_FIELD_POS = 56;
    localparam int unsigned ITEMS_PER_PHASE = 88;
    localparam int unsigned DRAIN_CYCLES = 200;

    class md5_digest_scoreboard;
        typedef struct packed {
            logic [31:0] word;
            logic [1:0]  number;
            logic        last;
        } digest_entry_t;

        logic [31:0]   chain [4];
        logic [7:0]    chunk_bytes [64];
        logic [60:0]   byte_total;
        int unsigned   fill;
        digest_entry_t expected_words [$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            byte_total = '0;
            fill = 0;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void compress_chunk();
            logic [31:0] m [16];
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            logic [31:0] d;
            logic [31:0] f;
            logic [31:0] sum;
            int g;
            int s;
            for (int w = 0; w < 16; w++)
            begin
                m[w] = {chunk_bytes[4*w+3], chunk_bytes[4*w+2],
                        chunk_bytes[4*w+1], chunk_bytes[4*w]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                case (i / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                s = MD5_ROT[(i / 16) * 4 + (i % 4)];
                sum = a + f + MD5_SINE[i] + m[g];
                a = d;
                d = c;
                c = b;
                b = b + ((sum << s) | (sum >> (32 - s)));
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
        endfunction

        function void note_item(logic [7:0] data, logic present, logic last);
            logic [63:0] bit_length;
            digest_entry_t e;
            if (present)
            begin
                chunk_bytes[fill] = data;
                byte_total = byte_total + 61'd1;
                fill = fill + 1;
                if (fill == 64)
                begin
                    compress_chunk();
                    fill = 0;
                end
            end
            if (!last)
                return;
            chunk_bytes[fill] = 8'h80;
            fill = fill + 1;
            if (fill > LENGTH_FIELD_POS)
            begin
                while (fill < 64)
                begin
                    chunk_bytes[fill] = 8'h00;
                    fill = fill + 1;
                end
                compress_chunk();
                fill = 0;
            end
            while (fill < LENGTH_FIELD_POS)
            begin
                chunk_bytes[fill] = 8'h00;
                fill = fill + 1;
            end
            bit_length = {byte_total, 3'b000};
            for (int k = 0; k < 8; k++)
                chunk_bytes[LENGTH_FIELD_POS + k] = bit_length[8*k +: 8];
            compress_chunk();
            for (int k = 0; k < 4; k++)
            begin
                e.word = chain[k];
                e.number = 2'(k);
                e.last = (k == 3);
                expected_words.push_back(e);
            end
            restart();
        endfunction

        function void check_result(logic [31:0] word, logic [1:0] number, logic last);
            digest_entry_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h number %0d last %0b",
                         $time, word, number, last);
                mismatches++;
                return;
            end
            e = expected_words.pop_front();
            if (word !== e.word)
            begin
                $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
                mismatches++;
            end
            if (number !== e.number)
            begin
                $display("%0t: word_number expected %0d actual %0d",
                         $time, e.number, number);
                mismatches++;
            end
            if (last !== e.last)
            begin
                $display("%0t: digest_last expected %0b actual %0b", $time, e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        digest_last;
    logic        out_valid;
    logic        out_stall;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned items_sent;

    md5_digest_scoreboard board = new();

    md5_message_digest_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .data_byte(data_byte),
        .byte_present(byte_present),
        .message_end(message_end),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .digest_word(digest_word),
        .word_number(word_number),
        .digest_last(digest_last),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(digest_word, word_number, digest_last);
    end

    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_present <= p;
        message_end <= e;
        @(negedge clk);
        while (in_stall)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        board.note_item(b, p, e);
        if (p || e)
            items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        logic split_end;
        split_end = (len == 0) ? 1'b1 : 1'($urandom_range(1));
        for (int unsigned n = 0; n < len; n++)
        begin
            if ($urandom_range(15) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, !split_end && n == len - 1);
        end
        if (split_end)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain_digests();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return $urandom_range(12);
        if (roll < 90)
            return 52 + $urandom_range(14);
        return 115 + $urandom_range(13);
    endfunction

    initial
    begin
        int unsigned phase_idle [4];
        int unsigned phase_stall [4];
        int unsigned phase_start;
        int unsigned msg_len;
        phase_idle = '{0, 57, 0, 10};
        phase_stall = '{0, 0, 57, 10};
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_present = 1'b0;
        message_end = 1'b0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        drain_digests();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                msg_len = pick_length();
                if (msg_len > ITEMS_PER_PHASE - (items_sent - phase_start))
                    msg_len = ITEMS_PER_PHASE - (items_sent - phase_start);
                send_message(msg_len);
            end
            drain_digests();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("md5_message_digest_core verification clean");
        else
            $display("md5_message_digest_core verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("md5_message_digest_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_front.sv
rtl/md5_queue.sv
rtl/md5_back.sv
rtl/md5_message_digest_core.sv
bench/tb.sv
